// ----- design/rcf_pkg.sv -----
// Package for the rational continued fraction block.
// Holds widths, limits and the sequencer state type; no dependencies.
package rcf_pkg;

    localparam int DATA_WIDTH      = 32;
    localparam int TERM_WIDTH      = DATA_WIDTH + 1;
    localparam int REM_WIDTH       = DATA_WIDTH + 2;
    localparam int CNT_WIDTH       = $clog2(TERM_WIDTH);
    localparam int TERM_LIMIT      = 48;
    localparam int N_WIDTH         = $clog2(TERM_LIMIT);
    localparam int IN_TDATA_WIDTH  = ((2 * DATA_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_WIDTH = ((TERM_WIDTH + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIX,
        ST_EMIT
    } t_state;

endpackage

// ----- design/rational_continued_fraction.sv -----
// Top level of the rational continued fraction block: Euclid's algorithm
// on a shared radix-2 restoring divider under a four-state sequencer.
// Depends on rcf_pkg.
//
// Takes one fraction (numerator, denominator) per input transaction and
// emits its simple continued fraction terms, floor(p/q) at each step, one
// per output transaction, the final one with tlast high. A negative
// denominator moves its sign to the numerator, so only the first term can
// be negative. A zero denominator gives a single term of zero with tuser
// (invalid) set. Each term passes through the divider, a sign-correction
// state and a hand-off state; a zero denominator goes straight to the
// hand-off. The input is ready only between items; the last term of an
// item may still wait on the output while the next item is taken.
module rational_continued_fraction (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [31:0] numerator, [63:32] denominator
    input  logic [rcf_pkg::IN_TDATA_WIDTH-1:0]  s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [32:0] term, zero padded above
    output logic [rcf_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata,
    output logic                                m_axis_tlast,
    // [0] invalid
    output logic                                m_axis_tuser
);

    localparam int W  = rcf_pkg::DATA_WIDTH;
    localparam int TW = rcf_pkg::TERM_WIDTH;
    localparam int RW = rcf_pkg::REM_WIDTH;
    localparam int CW = rcf_pkg::CNT_WIDTH;
    localparam int NW = rcf_pkg::N_WIDTH;
    localparam int OW = rcf_pkg::OUT_TDATA_WIDTH;

    rcf_pkg::t_state r_state, n_state;

    logic [TW-1:0] r_mag;     // dividend, shifting out; quotient shifting in
    logic [TW-1:0] r_rem;
    logic [TW-1:0] r_q;       // divisor, never negative
    logic          r_pneg;    // dividend is negative
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_n;
    logic [TW-1:0] r_a;
    logic [TW-1:0] r_r;
    logic          r_fin;
    logic          r_inv;

    logic [TW-1:0] r_out_term;
    logic          r_out_last;
    logic          r_out_inv;
    logic          r_out_valid;

    logic          in_fire;
    logic          out_free;
    logic          div_done;
    logic          den_zero;
    logic [W-1:0]  in_num;
    logic [W-1:0]  in_den;
    logic [TW-1:0] num_ext;
    logic [TW-1:0] den_ext;
    logic [TW-1:0] num_abs;
    logic [TW-1:0] den_abs;
    logic [RW-1:0] rem_sh;
    logic          step_ge;
    logic [TW-1:0] rem_lo;
    logic [TW-1:0] fix_a;
    logic [TW-1:0] fix_r;
    logic          fix_fin;

    assign in_num   = s_axis_tdata[W-1:0];
    assign in_den   = s_axis_tdata[2*W-1:W];
    assign num_ext  = {in_num[W-1], in_num};
    assign den_ext  = {in_den[W-1], in_den};
    assign num_abs  = in_num[W-1] ? (TW'(0) - num_ext) : num_ext;
    assign den_abs  = in_den[W-1] ? (TW'(0) - den_ext) : den_ext;
    assign den_zero = (in_den == W'(0));

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign div_done = (r_cnt == CW'(TW - 1));

    // one restoring division step
    assign rem_sh  = {r_rem, r_mag[TW-1]};
    assign step_ge = (rem_sh >= {1'b0, r_q});

    // floor correction for a negative dividend
    assign rem_lo = r_rem;
    always_comb begin
        if (r_pneg && (rem_lo != TW'(0))) begin
            fix_a = ~r_mag;
            fix_r = r_q - rem_lo;
        end else if (r_pneg) begin
            fix_a = TW'(0) - r_mag;
            fix_r = TW'(0);
        end else begin
            fix_a = r_mag;
            fix_r = rem_lo;
        end
    end
    assign fix_fin = (fix_r == TW'(0)) || (r_n == NW'(rcf_pkg::TERM_LIMIT - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rcf_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_state = den_zero ? rcf_pkg::ST_EMIT : rcf_pkg::ST_DIV;
                end
            end
            rcf_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = rcf_pkg::ST_FIX;
                end
            end
            rcf_pkg::ST_FIX: begin
                n_state = rcf_pkg::ST_EMIT;
            end
            rcf_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = r_fin ? rcf_pkg::ST_IDLE : rcf_pkg::ST_DIV;
                end
            end
            default: n_state = rcf_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_axis_tready = (r_state == rcf_pkg::ST_IDLE);
        m_axis_tvalid = r_out_valid;
        m_axis_tdata  = OW'(r_out_term);
        m_axis_tlast  = r_out_last;
        m_axis_tuser  = r_out_inv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rcf_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == rcf_pkg::ST_EMIT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            rcf_pkg::ST_IDLE: begin
                if (in_fire) begin
                    r_mag  <= num_abs;
                    r_q    <= den_abs;
                    r_pneg <= (in_num != W'(0)) && (in_num[W-1] ^ in_den[W-1]);
                    r_rem  <= TW'(0);
                    r_cnt  <= CW'(0);
                    r_n    <= NW'(0);
                    r_a    <= TW'(0);
                    r_fin  <= 1'b1;
                    r_inv  <= den_zero;
                end
            end
            rcf_pkg::ST_DIV: begin
                r_mag <= {r_mag[TW-2:0], step_ge};
                r_rem <= step_ge ? TW'(rem_sh - {1'b0, r_q}) : rem_sh[TW-1:0];
                r_cnt <= r_cnt + CW'(1);
            end
            rcf_pkg::ST_FIX: begin
                r_a   <= fix_a;
                r_r   <= fix_r;
                r_fin <= fix_fin;
            end
            rcf_pkg::ST_EMIT: begin
                if (out_free) begin
                    r_out_term <= r_a;
                    r_out_last <= r_fin;
                    r_out_inv  <= r_inv;
                    // (p, q) <- (q, r)
                    r_mag  <= r_q;
                    r_q    <= r_r;
                    r_pneg <= 1'b0;
                    r_rem  <= TW'(0);
                    r_cnt  <= CW'(0);
                    r_n    <= r_n + NW'(1);
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- verif/rational_continued_fraction_test.sv -----
// Testbench for rational_continued_fraction: streams signed fractions in and
// checks every continued fraction term against an in-bench Euclid expansion.
// Depends on rcf_pkg and the rational_continued_fraction RTL.
`timescale 1ns / 1ps

module rational_continued_fraction_test;

    localparam longint CYCLE_LIMIT  = 10_000_000;
    localparam int     DRAIN_CYCLES = 2000;
    localparam int     MAX_INT      = 2147483647;
    localparam int     MIN_INT      = -MAX_INT - 1;

    typedef struct {
        int num;
        int den;
        int gap;
    } t_fraction;

    typedef struct {
        logic signed [rcf_pkg::TERM_WIDTH-1:0] term;
        logic                                  last;
        logic                                  invalid;
    } t_term;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    // [31:0] numerator, [63:32] denominator
    logic [rcf_pkg::IN_TDATA_WIDTH-1:0]  s_axis_tdata = '0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    // [32:0] term, zero padded above
    logic [rcf_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata;
    logic                                m_axis_tlast;
    // [0] invalid
    logic                                m_axis_tuser;

    t_fraction pending_fractions[$];
    t_term     expected_terms[$];
    int        mismatches = 0;
    longint    cycle_count = 0;
    bit        holding = 1'b0;

    rational_continued_fraction DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Floor-division Euclid on widened values; queues one term per step.
    function automatic void expand_fraction(input int num, input int den);
        longint p;
        longint q;
        longint quot;
        longint rem;
        t_term  t;
        int     n;
        bit     fin;
        p = num;
        q = den;
        n = 0;
        if (q == 0) begin
            t.term    = '0;
            t.last    = 1'b1;
            t.invalid = 1'b1;
            expected_terms.push_back(t);
            return;
        end
        if (q < 0) begin
            p = -p;
            q = -q;
        end
        while (n < rcf_pkg::TERM_LIMIT) begin
            quot = p / q;
            rem  = p % q;
            if (rem < 0) begin
                quot = quot - 1;
                rem  = rem + q;
            end
            fin       = (rem == 0) || (n == rcf_pkg::TERM_LIMIT - 1);
            t.term    = quot[rcf_pkg::TERM_WIDTH-1:0];
            t.last    = fin;
            t.invalid = 1'b0;
            expected_terms.push_back(t);
            n++;
            if (fin) break;
            p = q;
            q = rem;
        end
    endfunction

    // Mostly short pauses, now and then a long one.
    function automatic int random_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_fraction(input int num, input int den, input int gap);
        t_fraction f;
        f.num = num;
        f.den = den;
        f.gap = gap;
        pending_fractions.push_back(f);
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(0, 5))
            0: return MIN_INT;
            1: return MAX_INT;
            2: return -1;
            3: return 0;
            4: return 1;
            default: return $urandom;
        endcase
    endfunction

    // Driver
    always @(posedge i_clk) begin
        static t_fraction cur = '{0, 0, 0};
        static int idle_left = 0;
        if (!i_rst_n) begin
            holding = 1'b0;
            idle_left = 0;
            s_axis_tvalid <= 1'b0;
        end else begin
            if (holding && s_axis_tready) begin
                expand_fraction(cur.num, cur.den);
                holding = 1'b0;
                idle_left = (pending_fractions.size() > 0) ? pending_fractions[0].gap : 0;
            end
            if (!holding) begin
                if (idle_left > 0) begin
                    idle_left--;
                end else if (pending_fractions.size() > 0) begin
                    cur = pending_fractions.pop_front();
                    holding = 1'b1;
                end
            end
            s_axis_tvalid <= holding;
            s_axis_tdata  <= {cur.den, cur.num};
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        static int ready_left = 0;
        static int stall_left = 0;
        t_term                                 exp_term;
        logic signed [rcf_pkg::TERM_WIDTH-1:0] act_term;
        if (!i_rst_n) begin
            ready_left = 0;
            stall_left = 0;
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                act_term = m_axis_tdata[rcf_pkg::TERM_WIDTH-1:0];
                if (expected_terms.size() == 0) begin
                    $error("unexpected transaction: term %0d last %0b invalid %0b",
                           act_term, m_axis_tlast, m_axis_tuser);
                    mismatches++;
                end else begin
                    exp_term = expected_terms.pop_front();
                    if (act_term !== exp_term.term) begin
                        $error("term: expected %0d, actual %0d", exp_term.term, act_term);
                        mismatches++;
                    end
                    if (m_axis_tlast !== exp_term.last) begin
                        $error("last: expected %0b, actual %0b", exp_term.last, m_axis_tlast);
                        mismatches++;
                    end
                    if (m_axis_tuser !== exp_term.invalid) begin
                        $error("invalid: expected %0b, actual %0b",
                               exp_term.invalid, m_axis_tuser);
                        mismatches++;
                    end
                end
            end
            if (stall_left == 0 && ready_left == 0) begin
                stall_left = random_pause();
                ready_left = $urandom_range(1, 300);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                ready_left--;
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("rational_continued_fraction: mismatch");
            $finish;
        end
    end

    initial begin
        longint fib[0:46];
        int     k;
        int     r;
        int     num;
        int     den;
        int     burst_left;
        int     gap;

        fib[0] = 0;
        fib[1] = 1;
        for (k = 2; k <= 46; k++) fib[k] = fib[k-1] + fib[k-2];

        // zero denominator, zero numerator, range extremes
        add_fraction(5, 0, 0);
        add_fraction(MIN_INT, 0, 1);
        add_fraction(0, 0, 0);
        add_fraction(0, 7, 2);
        add_fraction(0, MIN_INT, 0);
        add_fraction(MIN_INT, -1, 0);
        add_fraction(MAX_INT, 1, 3);
        add_fraction(MIN_INT, 1, 0);
        add_fraction(MAX_INT, MIN_INT, 0);
        add_fraction(MIN_INT, MIN_INT, 1);
        add_fraction(MAX_INT, MAX_INT, 0);
        add_fraction(1, MAX_INT, 0);
        add_fraction(MAX_INT, -MAX_INT, 0);
        // longest expansions
        add_fraction(int'(fib[45]), int'(fib[46]), 0);
        add_fraction(int'(fib[46]), int'(fib[45]), 5);
        add_fraction(-int'(fib[46]), int'(fib[45]), 0);
        add_fraction(int'(fib[45]), -int'(fib[46]), 0);
        // sign handling
        add_fraction(1, -1, 0);
        add_fraction(-1, 1, 0);
        add_fraction(3, 7, 0);
        add_fraction(-7, 3, 2);
        add_fraction(-7, -3, 0);
        add_fraction(355, 113, 0);

        burst_left = 0;
        for (k = 0; k < 347; k++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                num = $urandom;
                den = $urandom;
            end else if (r < 65) begin
                num = $urandom_range(0, 2000) - 1000;
                den = $urandom_range(0, 2000) - 1000;
            end else if (r < 75) begin
                num = int'(fib[$urandom_range(30, 46)]);
                den = int'(fib[$urandom_range(30, 46)]);
                if ($urandom_range(0, 1)) num = -num;
                if ($urandom_range(0, 1)) den = -den;
            end else if (r < 82) begin
                num = $urandom;
                den = $urandom;
                if ($urandom_range(0, 1)) den = 0;
                else num = 0;
            end else if (r < 92) begin
                num = pick_extreme();
                den = pick_extreme();
            end else begin
                num = $urandom;
                den = $urandom_range(0, 64) - 32;
            end
            if (burst_left > 0) begin
                burst_left--;
                gap = 0;
            end else if ($urandom_range(0, 19) == 0) begin
                burst_left = $urandom_range(5, 20);
                gap = 0;
            end else begin
                gap = random_pause();
            end
            add_fraction(num, den, gap);
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_fractions.size() > 0 || holding) @(posedge i_clk);
        while (expected_terms.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_terms.size() == 0) begin
            $display("rational_continued_fraction: match");
        end else begin
            $display("rational_continued_fraction: mismatch");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/rcf_pkg.sv
design/rational_continued_fraction.sv
verif/rational_continued_fraction_test.sv
